/* hdl/mfw_pkg.sv */
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared types, codes and helpers for the most frequent word table.
// ----------------------------------------------------------------------------
package mfw_pkg;

  // Default capacity of the word store.
  localparam int unsigned MFW_MAX_WORDS = 64;

  // Item actions.
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_QUERY   = 2'd2;

  // One stored word: characters 0 to 7 in low, character 8 in high.
  typedef struct packed {
    logic [7:0]  high;
    logic [63:0] low;
  } word_t;

  // Input transaction.
  typedef struct packed {
    logic        action;
    logic [63:0] word_low;
    logic [7:0]  word_high;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] top_word_low;
    logic [7:0]  top_word_high;
    logic [6:0]  top_count;
    logic [6:0]  stored_words;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_REF,
    S_SCAN,
    S_ROW
  } state_t;

  // Clear every byte after the first zero byte, so equal strings pack equally.
  function automatic word_t clean_word(logic [63:0] lo, logic [7:0] hi);
    word_t w;
    logic  seen;
    seen   = 1'b0;
    w.low  = lo;
    w.high = hi;
    for (int k = 0; k < 8; k++) begin
      if (lo[8*k +: 8] == 8'h00) seen = 1'b1;
      if (seen) w.low[8*k +: 8] = 8'h00;
    end
    if (seen) w.high = 8'h00;
    return w;
  endfunction

endpackage

/* hdl/mfw_ram.sv */
// ----------------------------------------------------------------------------
// mfw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/most_frequent_word_table.sv */
// ----------------------------------------------------------------------------
// most_frequent_word_table
// Ordered word store that reports the most frequent stored word.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken on a rising edge where start is high and busy
// is low; in_item carries the action and the word. Every transaction gives one
// result on out_item, marked by out_strobe for exactly one cycle; the receiver
// must take it then, it cannot stall the block.
// An add writes the cleaned word into the RAM at the fill position. Its result
// appears in the cycle after acceptance and busy stays low, so adds run at one
// per cycle. When the store is full the word is dropped with a dropped status.
// A query walks the store with the RAM's single read port: for each entry it
// reads the entry, then every later entry, counting matches. Busy stays high
// through the walk, and the result appears in the same cycle as busy falls;
// an empty store answers in the cycle after acceptance.
// Ties go to the word whose first occurrence comes earliest.
// Reset clears the fill count and the sequencer; the RAM is not cleared, since
// only written entries are ever read.
// ----------------------------------------------------------------------------
module most_frequent_word_table #(
  parameter int unsigned MAX_WORDS = mfw_pkg::MFW_MAX_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mfw_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output mfw_pkg::out_item_t out_item
);

  localparam int unsigned AW = $clog2(MAX_WORDS);
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned WW = $bits(mfw_pkg::word_t);

  mfw_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      best_r, best_nxt;
  logic               pend_r, pend_nxt;
  mfw_pkg::word_t     ref_r, ref_nxt;
  mfw_pkg::word_t     top_r, top_nxt;
  mfw_pkg::out_item_t out_r, out_nxt;
  logic               out_strobe_r, out_strobe_nxt;

  logic               accept;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  mfw_pkg::word_t     clean_w;
  logic [WW-1:0]      rd_bits;
  mfw_pkg::word_t     rd_word;
  logic [CW-1:0]      i_inc;
  logic               row_wins;
  logic               more_rows;

  assign accept    = start && (state_r == mfw_pkg::S_IDLE);
  assign busy      = (state_r != mfw_pkg::S_IDLE);
  assign clean_w   = mfw_pkg::clean_word(in_item.word_low, in_item.word_high);
  assign mem_waddr = fill_r[AW-1:0];
  assign rd_word   = mfw_pkg::word_t'(rd_bits);
  assign i_inc     = i_r + CW'(1);
  assign row_wins  = (cnt_r > best_r);
  assign more_rows = (i_inc < fill_r);

  // Word store.
  mfw_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (clean_w),
    .rd_addr (mem_raddr),
    .rd_data (rd_bits)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfw_pkg::S_IDLE: begin
        if (accept && in_item.action == mfw_pkg::ACT_QUERY && fill_r != '0) begin
          state_nxt = mfw_pkg::S_REF;
        end
      end
      mfw_pkg::S_REF:  state_nxt = mfw_pkg::S_SCAN;
      mfw_pkg::S_SCAN: begin
        if (j_r >= fill_r) state_nxt = mfw_pkg::S_ROW;
      end
      mfw_pkg::S_ROW:  state_nxt = more_rows ? mfw_pkg::S_REF : mfw_pkg::S_IDLE;
      default:         state_nxt = mfw_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM control and result assembly.
  always_comb begin
    fill_nxt       = fill_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    best_nxt       = best_r;
    pend_nxt       = pend_r;
    ref_nxt        = ref_r;
    top_nxt        = top_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    mem_we         = 1'b0;
    mem_raddr      = '0;
    unique case (state_r)
      mfw_pkg::S_IDLE: begin
        if (accept) begin
          if (in_item.action == mfw_pkg::ACT_ADD) begin
            out_nxt = '0;
            if (fill_r < CW'(MAX_WORDS)) begin
              mem_we         = 1'b1;
              fill_nxt       = fill_r + CW'(1);
              out_nxt.status = mfw_pkg::ST_ADDED;
            end else begin
              out_nxt.status = mfw_pkg::ST_DROPPED;
            end
            out_nxt.stored_words = 7'(fill_nxt);
            out_strobe_nxt       = 1'b1;
          end else if (fill_r == '0) begin
            out_nxt        = '0;
            out_nxt.status = mfw_pkg::ST_QUERY;
            out_strobe_nxt = 1'b1;
          end else begin
            // Start the walk at entry 0.
            mem_raddr = '0;
            i_nxt     = '0;
            best_nxt  = '0;
            top_nxt   = '0;
          end
        end
      end
      mfw_pkg::S_REF: begin
        // Entry i arrives: it is the reference and counts itself once.
        ref_nxt  = rd_word;
        cnt_nxt  = CW'(1);
        j_nxt    = i_inc;
        pend_nxt = 1'b0;
      end
      mfw_pkg::S_SCAN: begin
        if (pend_r && rd_word == ref_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (j_r < fill_r) begin
          mem_raddr = j_r[AW-1:0];
          j_nxt     = j_r + CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
        end
      end
      mfw_pkg::S_ROW: begin
        // Strictly greater keeps the earliest first occurrence on a tie.
        if (row_wins) begin
          best_nxt = cnt_r;
          top_nxt  = ref_r;
        end
        i_nxt = i_inc;
        if (more_rows) begin
          mem_raddr = i_inc[AW-1:0];
        end else begin
          out_nxt.status        = mfw_pkg::ST_QUERY;
          out_nxt.top_word_low  = row_wins ? ref_r.low  : top_r.low;
          out_nxt.top_word_high = row_wins ? ref_r.high : top_r.high;
          out_nxt.top_count     = 7'(row_wins ? cnt_r : best_r);
          out_nxt.stored_words  = 7'(fill_r);
          out_strobe_nxt        = 1'b1;
        end
      end
      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfw_pkg::S_IDLE;
      fill_r       <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    cnt_r  <= cnt_nxt;
    best_r <= best_nxt;
    ref_r  <= ref_nxt;
    top_r  <= top_nxt;
    out_r  <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

/* hdl/mfw_checker.sv */
// ----------------------------------------------------------------------------
// mfw_checker
// Port-level checks for the most frequent word table, bound to the top level.
// ----------------------------------------------------------------------------
module mfw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input mfw_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input mfw_pkg::out_item_t out_item
);

  // Reset leaves no result pending and the block ready.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("result or busy seen right after reset");

  // An accepted add answers in the next cycle with an add status.
  a_add_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.action == mfw_pkg::ACT_ADD |=>
      out_strobe && (out_item.status == mfw_pkg::ST_ADDED ||
                     out_item.status == mfw_pkg::ST_DROPPED))
    else $error("add transaction without a matching result");

  // An accepted query either starts a walk or answers at once.
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.action == mfw_pkg::ACT_QUERY |=>
      busy || (out_strobe && out_item.status == mfw_pkg::ST_QUERY))
    else $error("query transaction neither walked nor answered");

  // Add results carry no word and no count.
  a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status != mfw_pkg::ST_QUERY |->
      out_item.top_count == '0 && out_item.top_word_low == '0 &&
      out_item.top_word_high == '0)
    else $error("add result carries word or count");

  // No result is shown while a query walk is still running.
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> !out_strobe)
    else $error("result strobe during a query walk");

endmodule

bind most_frequent_word_table mfw_checker u_mfw_checker (.*);
